[rtl/core/multi_slot_software_timer_top_assert.svh]
// assertion macros for the timer slot bank
// expects clk and rst_n in the scope that uses them
`ifndef MULTI_SLOT_SOFTWARE_TIMER_TOP_ASSERT_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MSST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define MSST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MSST_ASSERT_IMP(lbl, ante, cons)
`define MSST_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/msst_pkg.sv]
// shared types and constants for the timer slot bank
// no dependencies
package msst_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = 32;
  localparam int RLD_W     = 31;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SWEEP = 2'b10
  } state_t;

  typedef struct packed {
    logic             run;
    logic             pend;
    logic             dis;
    logic [CNT_W-1:0] cnt;
    logic [RLD_W-1:0] rld;
  } slot_t;

endpackage

[rtl/core/msst_cell.sv]
// one cell of the slot ring: holds a single slot and takes its neighbor's on shift
// depends on msst_pkg
module msst_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  msst_pkg::slot_t d,
  output msst_pkg::slot_t q,
  output logic            fire
);

  msst_pkg::slot_t slot_r;
  msst_pkg::slot_t slot_nxt;

  always_comb begin
    slot_nxt = shift_en ? d : slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign q = slot_r;
  // will expire on the next tick: running or pending, no disarm, count at one or zero
  assign fire = (slot_r.run | slot_r.pend) & ~slot_r.dis &
                (slot_r.cnt[msst_pkg::CNT_W-1:1] == '0);

endmodule

[rtl/core/multi_slot_software_timer_top.sv]
// top level of the timer slot bank: command intake, ring of slot cells, result register
// depends on msst_pkg, msst_cell and multi_slot_software_timer_top_assert.svh
//
//  channel | dir | tdata                                    | tuser      | tlast
//  in_     | in  | slot[3:0] ticks[35:4] interval[66:36]    | cmd[1:0]   | -
//  out_    | out | out_slot[3:0] armed_flag[4] remaining[36:5] | fired    | last
//
// every command takes the idle state that takes the word in plus one full turn of
// the ring, a step per slot; a result that waits on a stalled output holds the ring;
// the head cell is the only place a slot is changed and, but for the fire flags taken
// at intake, the only place one is read, so the ring turn sets the rate.
// an addressed slot beyond the bank still turns the ring and reports at the end.
// reset clears every slot at once; no clearing pass.
`include "multi_slot_software_timer_top_assert.svh"

module multi_slot_software_timer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // slot, ticks, interval
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_slot, armed_flag, remaining
  output logic        out_tuser,  // fired
  output logic        out_tlast
);

  localparam int N  = msst_pkg::NUM_SLOTS;
  localparam int IW = msst_pkg::IDX_W;
  localparam int CW = msst_pkg::CNT_W;
  localparam int RW = msst_pkg::RLD_W;
  localparam int SW = msst_pkg::SLOT_W;

  msst_pkg::state_t state_r, state_nxt;
  msst_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [CW-1:0]    tk_r, tk_nxt;
  logic [RW-1:0]    iv_r, iv_nxt;
  logic             slot_ok_r, slot_ok_nxt;
  logic             quiet_r, quiet_nxt;
  logic [N-1:0]     rem_r, rem_nxt;
  logic [IW-1:0]    hd_r, hd_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_fired_r, out_fired_nxt;
  logic [SW-1:0]    out_slot_r, out_slot_nxt;
  logic             out_armed_r, out_armed_nxt;
  logic [CW-1:0]    out_rem_r, out_rem_nxt;
  logic             out_last_r, out_last_nxt;

  msst_pkg::slot_t  cell_q [N];
  msst_pkg::slot_t  head_upd;
  msst_pkg::slot_t  head;
  logic [N-1:0]     cell_fire;

  logic             in_acc;
  logic [SW-1:0]    in_slot;
  logic [CW-1:0]    in_ticks;
  logic             at_end;
  logic             hit;
  logic [N-1:0]     hd_bit;
  logic             emit;
  logic             e_fired;
  logic [SW-1:0]    e_slot;
  logic             e_armed;
  logic [CW-1:0]    e_rem;
  logic             e_last;
  logic             out_free;
  logic             step;

  // ring of cells, the head at position 0 wraps back into the tail
  for (genvar i = 0; i < N; i++) begin : g_cell
    msst_pkg::slot_t d;
    if (i == N - 1) begin : g_tail
      assign d = head_upd;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    msst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (step),
      .d        (d),
      .q        (cell_q[i]),
      .fire     (cell_fire[i])
    );
  end

  assign in_tready = (state_r == msst_pkg::ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign in_slot   = in_tdata[3:0];
  assign in_ticks  = in_tdata[35:4];

  assign head   = cell_q[0];
  assign at_end = (hd_r == IW'(N - 1));
  assign hit    = slot_ok_r && (32'(hd_r) == 32'(slot_r));
  assign hd_bit = N'(1) << hd_r;

  // slot update at the head cell
  always_comb begin
    head_upd = head;
    case (cmd_r)
      msst_pkg::CMD_TICK: begin
        if (head.pend) begin
          head_upd.pend = 1'b0;
          head_upd.run  = 1'b1;
        end
        if (head.run | head.pend) begin
          if (head.dis) begin
            head_upd.run = 1'b0;
            head_upd.dis = 1'b0;
          end else if (head.cnt > CW'(1)) begin
            head_upd.cnt = head.cnt - CW'(1);
          end else if (head.rld != '0) begin
            head_upd.cnt = CW'(head.rld);
          end else begin
            head_upd.cnt = '0;
            head_upd.run = 1'b0;
          end
        end
      end
      msst_pkg::CMD_ARM: begin
        if (hit) begin
          head_upd.cnt = tk_r;
          head_upd.rld = iv_r;
          head_upd.dis = 1'b0;
          if (!head.run && !head.pend) begin
            head_upd.pend = 1'b1;
          end
        end
      end
      msst_pkg::CMD_DISARM: begin
        if (hit) begin
          head_upd.cnt = '0;
          head_upd.rld = '0;
          head_upd.dis = 1'b1;
        end
      end
      default: begin
        head_upd = head;
      end
    endcase
  end

  // result for the current head position
  always_comb begin
    emit    = 1'b0;
    e_fired = 1'b0;
    e_slot  = slot_r;
    e_armed = 1'b0;
    e_rem   = '0;
    e_last  = 1'b1;
    case (cmd_r)
      msst_pkg::CMD_TICK: begin
        e_fired = cell_fire[0];
        e_slot  = cell_fire[0] ? SW'(hd_r) : '0;
        e_last  = cell_fire[0] ? ((rem_r & ~hd_bit) == '0) : 1'b1;
        emit    = cell_fire[0] || (at_end && quiet_r);
      end
      msst_pkg::CMD_ARM: begin
        emit = slot_ok_r ? hit : at_end;
      end
      msst_pkg::CMD_DISARM: begin
        emit    = slot_ok_r ? hit : at_end;
        e_armed = slot_ok_r & (head.run | head.pend);
      end
      msst_pkg::CMD_QUERY: begin
        emit    = slot_ok_r ? hit : at_end;
        e_armed = slot_ok_r & (head.run | head.pend) & ~head.dis;
        e_rem   = slot_ok_r ? head.cnt : '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign out_free = ~out_valid_r | out_tready;
  assign step     = (state_r == msst_pkg::ST_SWEEP) && (!emit || out_free);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    slot_nxt    = slot_r;
    tk_nxt      = tk_r;
    iv_nxt      = iv_r;
    slot_ok_nxt = slot_ok_r;
    quiet_nxt   = quiet_r;
    rem_nxt     = rem_r;
    hd_nxt      = hd_r;
    if (in_acc) begin
      cmd_nxt     = msst_pkg::cmd_t'(in_tuser);
      slot_nxt    = in_slot;
      tk_nxt      = (in_ticks == '0) ? CW'(1) : in_ticks;
      iv_nxt      = in_tdata[66:36];
      slot_ok_nxt = (32'(in_slot) < 32'(N));
      rem_nxt     = cell_fire;
      quiet_nxt   = (cell_fire == '0);
      state_nxt   = msst_pkg::ST_SWEEP;
    end else if (step) begin
      rem_nxt = rem_r & ~hd_bit;
      if (at_end) begin
        hd_nxt    = '0;
        state_nxt = msst_pkg::ST_IDLE;
      end else begin
        hd_nxt = hd_r + IW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_fired_nxt = out_fired_r;
    out_slot_nxt  = out_slot_r;
    out_armed_nxt = out_armed_r;
    out_rem_nxt   = out_rem_r;
    out_last_nxt  = out_last_r;
    if (step && emit) begin
      out_valid_nxt = 1'b1;
      out_fired_nxt = e_fired;
      out_slot_nxt  = e_slot;
      out_armed_nxt = e_armed;
      out_rem_nxt   = e_rem;
      out_last_nxt  = e_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msst_pkg::ST_IDLE;
      hd_r        <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hd_r        <= hd_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    slot_r      <= slot_nxt;
    tk_r        <= tk_nxt;
    iv_r        <= iv_nxt;
    slot_ok_r   <= slot_ok_nxt;
    quiet_r     <= quiet_nxt;
    out_fired_r <= out_fired_nxt;
    out_slot_r  <= out_slot_nxt;
    out_armed_r <= out_armed_nxt;
    out_rem_r   <= out_rem_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fired_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_rem_r, out_armed_r, out_slot_r};

  `MSST_ASSERT_IMP(a_idle_aligned, state_r == msst_pkg::ST_IDLE, hd_r == '0)
  `MSST_ASSERT_NXT(a_turn_ends, step && at_end, state_r == msst_pkg::ST_IDLE && hd_r == '0)
  `MSST_ASSERT_NXT(a_rem_shrinks, state_r == msst_pkg::ST_SWEEP, (rem_r & ~$past(rem_r)) == '0)

endmodule
